// ----- hw/rtl/scis_pkg.sv -----
`timescale 1ns / 1ps

package scis_pkg;

   localparam int Symbols = 4;
   localparam int Subcarriers = 240;
   localparam int GridSize = Symbols * Subcarriers;
   localparam int SymW = 2;
   localparam int ScW = 8;
   localparam int AddrW = 10;
   localparam int ColW = 9;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic start;
      logic signed [24:0] num;
      logic [ScW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic signed [16:0] quo;
   } div_rsp_type;

   function automatic logic [AddrW-1:0] grid_addr(input logic [SymW-1:0] s,
                                                  input logic [ScW-1:0] c);
      logic [AddrW+ScW:0] a;
      a = (AddrW+ScW+1)'(s) * (AddrW+ScW+1)'(Subcarriers) + (AddrW+ScW+1)'(c);
      return a[AddrW-1:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      if (v > 18'sd32767) return 16'sh7fff;
      if (v < -18'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

endpackage

// ----- hw/rtl/scis_div.sv -----
`timescale 1ns / 1ps

// Restoring divider with rounding to nearest, ties away from zero.
module scis_div (
   input  logic                       clock,
   input  logic                       reset,
   input  scis_pkg::div_req_type      req,
   output scis_pkg::div_rsp_type      rsp
);

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [25:0] rem_ff, rem_in;
   logic [24:0] q_ff, q_in;
   logic [24:0] dvd_ff, dvd_in;
   logic [7:0]  den_ff, den_in;
   logic        done_ff, done_in;
   logic [24:0] mag;
   logic [25:0] trial;
   logic [24:0] qq;

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      dvd_in = dvd_ff;
      den_in = den_ff;
      done_in = 1'b0;
      mag = req.num[24] ? 25'(-req.num) : 25'(req.num);
      trial = {rem_ff[24:0], dvd_ff[24]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = 5'd25;
         neg_in = req.num[24];
         // Adding half the divisor up front gives rounding half away from zero.
         dvd_in = mag + 25'(req.den[7:1]);
         den_in = req.den;
         rem_in = '0;
         q_in = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[23:0], 1'b0};
         if (trial >= 26'(den_ff)) begin
            rem_in = trial - 26'(den_ff);
            q_in = {q_ff[23:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[23:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      dvd_ff <= dvd_in;
      den_ff <= den_in;
   end

   always_comb begin
      qq = neg_ff ? -q_ff : q_ff;
      rsp.done = done_ff;
      rsp.quo = qq[16:0];
   end

`ifndef SYNTH
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.done |-> $past(busy_ff)) else $error("divider done without work");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      rsp.done |-> !busy_ff) else $error("divider still busy at done");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      req.start |-> req.den != 8'd0) else $error("divider given zero");
`endif

endmodule

// ----- hw/rtl/ssb_channel_interp_smooth.sv -----
`timescale 1ns / 1ps

// Pilot channel estimate grid with interpolation and symbol smoothing.
// Items enter on the req_ ports when start is high and busy is low.
// A write stores one entry and its valid mark; busy stays low.
// A clear drops all marks by sweeping the mark memory.
// A read scans up to three symbol rows one subcarrier at a time for the
// nearest valid neighbours on each side, interpolates with the shared
// serial divider, then smooths across symbols with the same divider.
// Each row scans up to 241 columns, reading then checking each one, and
// then interpolates with two divisions when two distinct neighbours are
// found. The smoothing divisions and the result follow; a read finishes
// far sooner when neighbours are close.
// The result appears on rsp_est_real and rsp_est_imag for one cycle with
// rsp_valid high; the receiver cannot stall. Reads out of the grid give
// zero, writes out of the grid are dropped, unused codes are ignored.
// After reset the block sweeps the mark memory with busy high before it
// takes the first item.
module ssb_channel_interp_smooth (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [1:0]         req_symbol,
   input  logic [7:0]         req_subcarrier,
   input  logic signed [15:0] req_value_real,
   input  logic signed [15:0] req_value_imag,
   input  logic               req_mark_valid,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_est_real,
   output logic signed [15:0] rsp_est_imag
);

   typedef enum logic [13:0] {
      S_CLR   = 14'b00000000000001,
      S_IDLE  = 14'b00000000000010,
      S_ROW   = 14'b00000000000100,
      S_LRD   = 14'b00000000001000,
      S_LCHK  = 14'b00000000010000,
      S_RRD   = 14'b00000000100000,
      S_RCHK  = 14'b00000001000000,
      S_VRD   = 14'b00000010000000,
      S_VCAP  = 14'b00000100000000,
      S_MUL   = 14'b00001000000000,
      S_DIVR  = 14'b00010000000000,
      S_DIVI  = 14'b00100000000000,
      S_ACC   = 14'b01000000000000,
      S_OUT   = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] est_mem [scis_pkg::GridSize];
   logic        mark_mem [scis_pkg::GridSize];
   logic [31:0] est_rd_ff;
   logic        mark_rd_ff;
   logic [scis_pkg::AddrW-1:0] addr;
   logic        mark_we, mark_wd, est_we;

   logic [scis_pkg::AddrW-1:0] clr_ff, clr_in;
   logic [1:0]  sym_ff, sym_in;
   logic [7:0]  sc_ff, sc_in;
   logic [1:0]  row_ff, row_in;
   logic [1:0]  rowcnt_ff, rowcnt_in;
   logic [scis_pkg::ColW-1:0] k_ff, k_in;
   logic [scis_pkg::ColW-1:0] lft_ff, lft_in, rgt_ff, rgt_in;
   logic        lok_ff, lok_in, rok_ff, rok_in;
   logic        vsel_ff, vsel_in;
   logic signed [15:0] ar_ff, ar_in, ai_ff, ai_in, br_ff, br_in, bi_ff, bi_in;
   logic signed [15:0] hr_ff, hr_in, hi_ff, hi_in;
   logic signed [24:0] nr_ff, nr_in, ni_ff, ni_in;
   logic signed [18:0] accr_ff, accr_in, acci_ff, acci_in;
   logic [2:0]  wsum_ff, wsum_in;
   logic        smooth_ff, smooth_in;
   logic        out_ff, out_in;
   logic signed [15:0] or_ff, or_in, oi_ff, oi_in;
   logic        wait_ff, wait_in;
   logic        kick;
   logic signed [24:0] kick_num;
   logic [7:0]  kick_den;
   logic signed [9:0] wl, wr;
   scis_pkg::div_req_type dreq;
   scis_pkg::div_rsp_type drsp;
   logic signed [15:0] qs;

   scis_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      dreq.start = kick;
      dreq.num = kick_num;
      dreq.den = kick_den;
      qs = scis_pkg::sat16(18'(drsp.quo));
      wl = 10'(rgt_ff) - 10'(sc_ff);
      wr = 10'(sc_ff) - 10'(lft_ff);
   end

   always_ff @(posedge clock) begin
      if (est_we) begin
         est_mem[addr] <= {req_value_real, req_value_imag};
      end
      est_rd_ff <= est_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[addr] <= mark_wd;
      end
      mark_rd_ff <= mark_mem[addr];
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      sym_in = sym_ff; sc_in = sc_ff; row_in = row_ff; rowcnt_in = rowcnt_ff;
      k_in = k_ff; lft_in = lft_ff; rgt_in = rgt_ff; lok_in = lok_ff; rok_in = rok_ff;
      vsel_in = vsel_ff;
      ar_in = ar_ff; ai_in = ai_ff; br_in = br_ff; bi_in = bi_ff;
      hr_in = hr_ff; hi_in = hi_ff; nr_in = nr_ff; ni_in = ni_ff;
      accr_in = accr_ff; acci_in = acci_ff; wsum_in = wsum_ff;
      smooth_in = smooth_ff; out_in = 1'b0; or_in = or_ff; oi_in = oi_ff;
      wait_in = wait_ff;
      kick = 1'b0; kick_num = '0; kick_den = 8'd1;
      addr = scis_pkg::grid_addr(row_ff, k_ff[7:0]);
      mark_we = 1'b0; mark_wd = 1'b0; est_we = 1'b0;
      unique case (state_ff)
         S_CLR: begin
            addr = clr_ff;
            mark_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == scis_pkg::AddrW'(scis_pkg::GridSize - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            addr = scis_pkg::grid_addr(req_symbol, req_subcarrier);
            if (start) begin
               unique case (req_operation)
                  scis_pkg::OP_WRITE: begin
                     if (32'(req_symbol) < scis_pkg::Symbols &&
                         32'(req_subcarrier) < scis_pkg::Subcarriers) begin
                        est_we = 1'b1;
                        mark_we = 1'b1;
                        mark_wd = req_mark_valid;
                     end
                  end
                  scis_pkg::OP_CLEAR: begin
                     clr_in = '0;
                     state_in = S_CLR;
                  end
                  scis_pkg::OP_READ: begin
                     if (32'(req_symbol) < scis_pkg::Symbols &&
                         32'(req_subcarrier) < scis_pkg::Subcarriers) begin
                        sym_in = req_symbol;
                        sc_in = req_subcarrier;
                        accr_in = '0; acci_in = '0; wsum_in = '0;
                        rowcnt_in = 2'd0;
                        state_in = S_ROW;
                     end else begin
                        or_in = '0; oi_in = '0;
                        state_in = S_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ROW: begin
            // Rows s-1, s, s+1 in turn; skip those outside the grid.
            if (rowcnt_ff == 2'd3) begin
               smooth_in = 1'b1;
               nr_in = 25'(accr_ff); ni_in = 25'(acci_ff);
               state_in = S_DIVR;
               wait_in = 1'b0;
            end else if ((rowcnt_ff == 2'd0 && sym_ff == 2'd0) ||
                         (rowcnt_ff == 2'd2 &&
                          32'(sym_ff) + 1 >= scis_pkg::Symbols)) begin
               rowcnt_in = rowcnt_ff + 2'd1;
            end else begin
               row_in = 2'(sym_ff + rowcnt_ff - 2'd1);
               k_in = 9'(sc_ff);
               lok_in = 1'b0; rok_in = 1'b0;
               state_in = S_LRD;
            end
         end
         S_LRD: state_in = S_LCHK;
         S_LCHK: begin
            if (mark_rd_ff) begin
               lok_in = 1'b1; lft_in = k_ff;
               k_in = 9'(sc_ff);
               state_in = S_RRD;
            end else if (k_ff == '0) begin
               k_in = 9'(sc_ff);
               state_in = S_RRD;
            end else begin
               k_in = k_ff - 1'b1;
               state_in = S_LRD;
            end
         end
         S_RRD: state_in = S_RCHK;
         S_RCHK: begin
            if (mark_rd_ff) begin
               rok_in = 1'b1; rgt_in = k_ff;
               k_in = lok_ff ? lft_ff : k_ff;
               vsel_in = 1'b0;
               state_in = S_VRD;
            end else if (32'(k_ff) + 1 >= scis_pkg::Subcarriers) begin
               k_in = lft_ff;
               vsel_in = 1'b0;
               state_in = lok_ff ? S_VRD : S_ACC;
               hr_in = '0; hi_in = '0;
            end else begin
               k_in = k_ff + 1'b1;
               state_in = S_RRD;
            end
         end
         S_VRD: state_in = S_VCAP;
         S_VCAP: begin
            if (!vsel_ff) begin
               ar_in = est_rd_ff[31:16]; ai_in = est_rd_ff[15:0];
            end else begin
               br_in = est_rd_ff[31:16]; bi_in = est_rd_ff[15:0];
            end
            if (!vsel_ff && lok_ff && rok_ff && lft_ff != rgt_ff) begin
               vsel_in = 1'b1;
               k_in = rgt_ff;
               state_in = S_VRD;
            end else if (vsel_ff) begin
               state_in = S_MUL;
            end else begin
               hr_in = est_rd_ff[31:16]; hi_in = est_rd_ff[15:0];
               state_in = S_ACC;
            end
         end
         S_MUL: begin
            nr_in = 25'(wl) * 25'(ar_ff) + 25'(wr) * 25'(br_ff);
            ni_in = 25'(wl) * 25'(ai_ff) + 25'(wr) * 25'(bi_ff);
            smooth_in = 1'b0;
            wait_in = 1'b0;
            state_in = S_DIVR;
         end
         S_DIVR: begin
            kick_num = nr_ff;
            kick_den = smooth_ff ? 8'(wsum_ff) : 8'(rgt_ff - lft_ff);
            if (!wait_ff) begin
               kick = 1'b1;
               wait_in = 1'b1;
            end else if (drsp.done) begin
               if (smooth_ff) or_in = qs; else hr_in = qs;
               wait_in = 1'b0;
               state_in = S_DIVI;
            end
         end
         S_DIVI: begin
            kick_num = ni_ff;
            kick_den = smooth_ff ? 8'(wsum_ff) : 8'(rgt_ff - lft_ff);
            if (!wait_ff) begin
               kick = 1'b1;
               wait_in = 1'b1;
            end else if (drsp.done) begin
               if (smooth_ff) begin
                  oi_in = qs;
                  state_in = S_OUT;
               end else begin
                  hi_in = qs;
                  state_in = S_ACC;
               end
            end
         end
         S_ACC: begin
            if (rowcnt_ff == 2'd1) begin
               accr_in = accr_ff + 19'(hr_ff) + 19'(hr_ff);
               acci_in = acci_ff + 19'(hi_ff) + 19'(hi_ff);
               wsum_in = wsum_ff + 3'd2;
            end else begin
               accr_in = accr_ff + 19'(hr_ff);
               acci_in = acci_ff + 19'(hi_ff);
               wsum_in = wsum_ff + 3'd1;
            end
            rowcnt_in = rowcnt_ff + 2'd1;
            state_in = S_ROW;
         end
         S_OUT: begin
            out_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         out_ff <= 1'b0;
         wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         out_ff <= out_in;
         wait_ff <= wait_in;
      end
      sym_ff <= sym_in; sc_ff <= sc_in; row_ff <= row_in; rowcnt_ff <= rowcnt_in;
      k_ff <= k_in; lft_ff <= lft_in; rgt_ff <= rgt_in; lok_ff <= lok_in; rok_ff <= rok_in;
      vsel_ff <= vsel_in;
      ar_ff <= ar_in; ai_ff <= ai_in; br_ff <= br_in; bi_ff <= bi_in;
      hr_ff <= hr_in; hi_ff <= hi_in; nr_ff <= nr_in; ni_ff <= ni_in;
      accr_ff <= accr_in; acci_ff <= acci_in; wsum_ff <= wsum_in;
      smooth_ff <= smooth_in; or_ff <= or_in; oi_ff <= oi_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = out_ff;
   assign rsp_est_real = or_ff;
   assign rsp_est_imag = oi_ff;

`ifndef SYNTH
   a_out_after_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_OUT)) else $error("result without read");
   a_out_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_wsum_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVR && smooth_ff) |-> (wsum_ff >= 3'd2 && wsum_ff <= 3'd4))
      else $error("bad weight sum");
`endif

endmodule
